// ----- hw/rtl/xie_pkg.sv -----
// Shared types and constants for the x86-64 instruction byte encoder.
`default_nettype none
package xie_pkg;
	localparam int MAX_BYTES = 10;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [4:0] ACT_NOP = 5'd0;
	localparam logic [4:0] ACT_RET = 5'd1;
	localparam logic [4:0] ACT_SYSCALL = 5'd2;
	localparam logic [4:0] ACT_INT = 5'd3;
	localparam logic [4:0] ACT_PUSH = 5'd4;
	localparam logic [4:0] ACT_POP = 5'd5;
	localparam logic [4:0] ACT_MOV = 5'd6;
	localparam logic [4:0] ACT_XOR = 5'd7;
	localparam logic [4:0] ACT_AND = 5'd8;
	localparam logic [4:0] ACT_OR = 5'd9;
	localparam logic [4:0] ACT_CMP = 5'd10;
	localparam logic [4:0] ACT_TEST = 5'd11;
	localparam logic [4:0] ACT_ADD = 5'd12;
	localparam logic [4:0] ACT_SUB = 5'd13;
	localparam logic [4:0] ACT_CALL = 5'd14;
	localparam logic [4:0] ACT_JMP = 5'd15;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_MISSING = 3'd1;
	localparam logic [2:0] ERR_BAD_DST = 3'd2;
	localparam logic [2:0] ERR_BAD_SRC = 3'd3;
	localparam logic [2:0] ERR_UNIMPL = 3'd4;

	typedef struct packed {
		logic [4:0] action;
		logic dst_present;
		logic dst_is_reg;
		logic [3:0] dst_reg;
		logic src_present;
		logic src_is_imm;
		logic src_is_reg;
		logic [3:0] src_reg;
		logic signed [63:0] immediate;
	} instr_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic last;
		logic [2:0] error_code;
	} result_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [3:0] count;
		logic [2:0] err;
	} enc_t;
endpackage
`default_nettype wire

// ----- hw/rtl/xie_front.sv -----
// Front end: checks the operands of one instruction and builds its byte string.
`default_nettype none
module xie_front (
	input wire xie_pkg::instr_t instr,
	output xie_pkg::enc_t enc
);
	import xie_pkg::*;

	function automatic logic [7:0] rex(input logic w, input logic [3:0] r, input logic [3:0] b);
		rex = {4'h4, w, r[3], 1'b0, b[3]};
	endfunction

	function automatic logic [7:0] modrm(input logic [2:0] reg_f, input logic [3:0] rm);
		modrm = {2'b11, reg_f, rm[2:0]};
	endfunction

	function automatic logic [7:0] reg_opcode(input logic [4:0] act);
		case (act)
			ACT_MOV: reg_opcode = 8'h89;
			ACT_XOR: reg_opcode = 8'h31;
			ACT_AND: reg_opcode = 8'h21;
			ACT_OR: reg_opcode = 8'h09;
			ACT_CMP: reg_opcode = 8'h39;
			ACT_TEST: reg_opcode = 8'h85;
			ACT_ADD: reg_opcode = 8'h01;
			default: reg_opcode = 8'h29;
		endcase
	endfunction

	function automatic logic [2:0] group_digit(input logic [4:0] act);
		case (act)
			ACT_AND: group_digit = 3'd4;
			ACT_OR: group_digit = 3'd1;
			ACT_CMP: group_digit = 3'd7;
			ACT_ADD: group_digit = 3'd0;
			default: group_digit = 3'd5;
		endcase
	endfunction

	logic [7:0] b [MAX_BYTES];
	logic [3:0] n;
	logic [2:0] err;
	logic [63:0] imm;
	logic [3:0] d;
	logic [3:0] s;

	always_comb begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			b[i] = 8'h00;
		end
		n = 4'd0;
		err = ERR_OK;
		imm = instr.immediate;
		d = instr.dst_reg;
		s = instr.src_reg;
		unique case (instr.action) inside
			ACT_NOP: begin
				b[n] = 8'h90; n = n + 4'd1;
			end
			ACT_RET: begin
				b[n] = 8'hC3; n = n + 4'd1;
			end
			ACT_SYSCALL: begin
				b[n] = 8'h0F; n = n + 4'd1;
				b[n] = 8'h05; n = n + 4'd1;
			end
			ACT_INT: begin
				if (!instr.dst_present) begin
					err = ERR_MISSING;
				end else if (imm == 64'd3) begin
					b[n] = 8'hCC; n = n + 4'd1;
				end else begin
					b[n] = 8'hCD; n = n + 4'd1;
					b[n] = imm[7:0]; n = n + 4'd1;
				end
			end
			ACT_PUSH, ACT_POP, ACT_CALL, ACT_JMP: begin
				if (!instr.dst_present) begin
					err = ERR_MISSING;
				end else if (!instr.dst_is_reg) begin
					err = ERR_BAD_DST;
				end else begin
					if (d[3]) begin
						b[n] = 8'h41; n = n + 4'd1;
					end
					if (instr.action == ACT_PUSH) begin
						b[n] = 8'h50 | {5'd0, d[2:0]}; n = n + 4'd1;
					end else if (instr.action == ACT_POP) begin
						b[n] = 8'h58 | {5'd0, d[2:0]}; n = n + 4'd1;
					end else begin
						b[n] = 8'hFF; n = n + 4'd1;
						b[n] = modrm((instr.action == ACT_CALL) ? 3'd2 : 3'd4, d);
						n = n + 4'd1;
					end
				end
			end
			ACT_MOV, ACT_XOR, ACT_AND, ACT_OR, ACT_CMP, ACT_TEST, ACT_ADD, ACT_SUB: begin
				if (!instr.dst_present || !instr.src_present) begin
					err = ERR_MISSING;
				end else if (!instr.dst_is_reg) begin
					err = ERR_BAD_DST;
				end else if (instr.action == ACT_XOR) begin
					if (!instr.src_is_reg) begin
						err = ERR_BAD_SRC;
					end else begin
						if (d != s) begin
							b[n] = rex(1'b1, s, d); n = n + 4'd1;
						end else if (d[3]) begin
							b[n] = rex(1'b0, s, d); n = n + 4'd1;
						end
						b[n] = 8'h31; n = n + 4'd1;
						b[n] = modrm(s[2:0], d); n = n + 4'd1;
					end
				end else if (!instr.src_is_imm && !instr.src_is_reg) begin
					err = ERR_BAD_SRC;
				end else if (instr.src_is_imm) begin
					b[n] = rex(1'b1, 4'd0, d); n = n + 4'd1;
					if (instr.action == ACT_MOV) begin
						b[n] = 8'hB8 | {5'd0, d[2:0]}; n = n + 4'd1;
						for (int k = 0; k < 8; k++) begin
							b[n] = imm[8*k +: 8]; n = n + 4'd1;
						end
					end else if (instr.action == ACT_TEST) begin
						b[n] = 8'hF7; n = n + 4'd1;
						b[n] = modrm(3'd0, d); n = n + 4'd1;
						for (int k = 0; k < 4; k++) begin
							b[n] = imm[8*k +: 8]; n = n + 4'd1;
						end
					end else begin
						// Add and sub clamp the immediate to the signed 32-bit range.
						if ((instr.action == ACT_ADD || instr.action == ACT_SUB)
							&& !((&imm[63:31]) || !(|imm[63:31]))) begin
							imm = imm[63] ? 64'hFFFF_FFFF_8000_0000 : 64'h0000_0000_7FFF_FFFF;
						end
						if ((&imm[63:7]) || !(|imm[63:7])) begin
							b[n] = 8'h83; n = n + 4'd1;
							b[n] = modrm(group_digit(instr.action), d); n = n + 4'd1;
							b[n] = imm[7:0]; n = n + 4'd1;
						end else begin
							b[n] = 8'h81; n = n + 4'd1;
							b[n] = modrm(group_digit(instr.action), d); n = n + 4'd1;
							for (int k = 0; k < 4; k++) begin
								b[n] = imm[8*k +: 8]; n = n + 4'd1;
							end
						end
					end
				end else begin
					b[n] = rex(1'b1, s, d); n = n + 4'd1;
					b[n] = reg_opcode(instr.action); n = n + 4'd1;
					b[n] = modrm(s[2:0], d); n = n + 4'd1;
				end
			end
			default: begin
				err = ERR_UNIMPL;
			end
		endcase
	end

	always_comb begin
		enc.err = err;
		if (err != ERR_OK) begin
			enc.count = 4'd1;
			enc.bytes = '0;
		end else begin
			enc.count = n;
			for (int i = 0; i < MAX_BYTES; i++) begin
				enc.bytes[i] = b[i];
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/xie_queue.sv -----
// Short queue of encoded instructions between the front end and the serializer.
`default_nettype none
module xie_queue #(
	parameter int DEPTH = xie_pkg::QUEUE_DEPTH
) (
	input wire clk,
	input wire arst_n,
	input wire wr,
	input wire xie_pkg::enc_t wr_data,
	output logic full,
	input wire rd,
	output logic not_empty,
	output xie_pkg::enc_t rd_data
);
	import xie_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	enc_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && not_empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy beyond depth");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue occupancy did not grow on a lone write");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CW'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with occupancy");
endmodule
`default_nettype wire

// ----- hw/rtl/xie_back.sv -----
// Back end: walks the bytes of the oldest encoded instruction into the result register.
`default_nettype none
module xie_back (
	input wire clk,
	input wire arst_n,
	input wire q_valid,
	input wire xie_pkg::enc_t q_data,
	output logic q_pop,
	output logic empty,
	input wire pop,
	output xie_pkg::result_t result
);
	import xie_pkg::*;

	logic [3:0] idx_q;
	logic out_valid_q;
	result_t result_q;
	logic load;
	logic at_last;

	assign load = q_valid && (!out_valid_q || pop);
	assign at_last = (idx_q == q_data.count - 4'd1);
	assign q_pop = load && at_last;
	assign empty = !out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= at_last ? 4'd0 : idx_q + 4'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.out_byte <= q_data.bytes[idx_q];
			result_q.last <= at_last;
			result_q.error_code <= q_data.err;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < 4'(MAX_BYTES))
		else $error("byte index beyond the longest encoding");
	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (idx_q == 4'd0) && result_q.last)
		else $error("final byte did not rewind the byte index");
endmodule
`default_nettype wire

// ----- hw/rtl/x64_instruction_byte_encoder.sv -----
// Top level of the x86-64 instruction byte encoder.
// Each accepted request is one parsed instruction; it comes back as 1 to 10 results, one
// machine code byte each, with last set on the final byte, or as a single result with a
// nonzero error code. The front end encodes an instruction in the cycle it is pushed and
// files it into a queue of QUEUE_DEPTH entries, so push is taken every cycle while the
// queue has room. The serializer emits one byte per cycle while the result register is empty
// or is popped; an instruction has as many results as bytes (1 to 10, ten for mov with a
// 64-bit immediate). Each byte is held in a queue entry and then in the result register.
`default_nettype none
module x64_instruction_byte_encoder #(
	parameter int QUEUE_DEPTH = xie_pkg::QUEUE_DEPTH
) (
	input wire clk,
	input wire arst_n,
	input wire push,
	output logic full,
	input wire xie_pkg::instr_t instr,
	output logic empty,
	input wire pop,
	output xie_pkg::result_t result
);
	import xie_pkg::*;

	enc_t enc;
	enc_t head;
	logic head_valid;
	logic head_pop;

	xie_front u_front (
		.instr(instr),
		.enc(enc)
	);

	xie_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(push),
		.wr_data(enc),
		.full(full),
		.rd(head_pop),
		.not_empty(head_valid),
		.rd_data(head)
	);

	xie_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(head_valid),
		.q_data(head),
		.q_pop(head_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);
endmodule
`default_nettype wire
